>>> hdl/ater_pkg.sv
package ater_pkg;

    // Byte codes
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_RBR   = 8'h5D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] FINAL_LO = 8'h40;
    localparam logic [7:0] FINAL_HI = 8'h7E;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_J     = 8'h4A;
    localparam logic [7:0] CH_K     = 8'h4B;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_M     = 8'h6D;

    // Command codes
    localparam logic [1:0] CMD_GLYPH  = 2'd0;
    localparam logic [1:0] CMD_FILL   = 2'd1;
    localparam logic [1:0] CMD_SCROLL = 2'd2;

    // CSI final codes
    localparam logic [3:0] FIN_NONE = 4'd0;
    localparam logic [3:0] FIN_POS  = 4'd1;
    localparam logic [3:0] FIN_CLR  = 4'd2;
    localparam logic [3:0] FIN_EL   = 4'd3;
    localparam logic [3:0] FIN_UP   = 4'd4;
    localparam logic [3:0] FIN_DN   = 4'd5;
    localparam logic [3:0] FIN_RT   = 4'd6;
    localparam logic [3:0] FIN_LT   = 4'd7;
    localparam logic [3:0] FIN_SGR  = 4'd8;

    // Parameter parse phases
    localparam logic [1:0] PH_LEAD  = 2'd0;
    localparam logic [1:0] PH_SIGN  = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;
    localparam logic [1:0] PH_STOP  = 2'd3;

    // Register byte addresses
    localparam logic [2:0] ADDR_WIDTH_REG  = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT_REG = 3'd4;

    localparam logic [11:0] FIELD_MAX = 12'd4095;
    localparam logic [2:0]  FORE_RESET = 3'd7;
    localparam logic [2:0]  BACK_RESET = 3'd0;
    localparam logic [10:0] WIDTH_RESET  = 11'd1280;
    localparam logic [10:0] HEIGHT_RESET = 11'd720;

    // Classified input word
    typedef struct packed {
        logic [7:0] byte_val;
        logic       is_bs;
        logic       is_bel;
        logic       is_esc;
        logic       is_lbr;
        logic       is_rbr;
        logic       is_cr;
        logic       is_lf;
        logic       is_final;
        logic       is_semi;
        logic       is_digit;
        logic       is_ws;
        logic       is_plus;
        logic       is_minus;
        logic [3:0] fin;
    } cls_t;

    // Result word
    typedef struct packed {
        logic [1:0]  command;
        logic [10:0] pos_x;
        logic [10:0] pos_y;
        logic [10:0] rect_width;
        logic [10:0] rect_height;
        logic [7:0]  glyph;
        logic [2:0]  fore_index;
        logic [2:0]  back_index;
        logic        last;
    } res_t;

endpackage

>>> hdl/ansi_terminal_escape_renderer.sv
// Terminal byte renderer: takes one byte per clock, while full is low, through a push/full
// queue port and turns ESC/CSI/OSC sequences and plain text into draw-glyph, fill-rectangle
// and scroll commands on a pop/empty result port. A byte is classified on entry and parked in
// a two-word input queue; the execute stage then handles one byte per cycle, writing a byte's
// results into the result queue as it takes the byte. The execute stage waits while the
// four-word result queue has fewer than two free words: sustained rate is one byte per cycle
// as long as results are popped, and a byte that wraps and scrolls takes two result words.
// Screen width and height are APB registers at byte addresses 0 and 4; write them only while
// the block is idle.
module ansi_terminal_escape_renderer #(
    parameter int GLYPH_WIDTH  = 12,
    parameter int GLYPH_HEIGHT = 16,
    parameter int LINE_PITCH   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  byte_in,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  command,
    output logic [10:0] pos_x,
    output logic [10:0] pos_y,
    output logic [10:0] rect_width,
    output logic [10:0] rect_height,
    output logic [7:0]  glyph,
    output logic [2:0]  fore_index,
    output logic [2:0]  back_index,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ater_pkg::*;

    logic [10:0] width_reg, width_next;
    logic [10:0] height_reg, height_next;
    cls_t        cls_in, cls_q;
    logic        q_valid, q_pop, room;
    logic [1:0]  res_count;
    res_t        res_a, res_b, head;

    // Register port
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {21'd0, height_reg} : {21'd0, width_reg};

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (psel && penable && pwrite)
        begin
            if ((paddr & ADDR_HEIGHT_REG) == ADDR_HEIGHT_REG)
            begin
                height_next = pwdata[10:0];
            end
            else
            begin
                width_next = pwdata[10:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Front: classify and queue
    ater_front u_front (
        .byte_in (byte_in),
        .cls     (cls_in)
    );

    ater_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (cls_in),
        .full      (full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_word  (cls_q)
    );

    // Back: execute and queue results
    ater_exec #(
        .GLYPH_WIDTH  (GLYPH_WIDTH),
        .GLYPH_HEIGHT (GLYPH_HEIGHT),
        .LINE_PITCH   (LINE_PITCH)
    ) u_exec (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_word        (cls_q),
        .q_pop         (q_pop),
        .room          (room),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .res_count     (res_count),
        .res_a         (res_a),
        .res_b         (res_b)
    );

    ater_resq u_resq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (res_count),
        .push_a     (res_a),
        .push_b     (res_b),
        .room       (room),
        .pop        (pop),
        .empty      (empty),
        .head       (head)
    );

    assign command     = head.command;
    assign pos_x       = head.pos_x;
    assign pos_y       = head.pos_y;
    assign rect_width  = head.rect_width;
    assign rect_height = head.rect_height;
    assign glyph       = head.glyph;
    assign fore_index  = head.fore_index;
    assign back_index  = head.back_index;
    assign last        = head.last;

endmodule

>>> hdl/ater_front.sv
module ater_front (
    input  logic [7:0]    byte_in,
    output ater_pkg::cls_t cls
);
    import ater_pkg::*;

    // Classify the byte on its value alone; the back stage applies parse state
    always_comb
    begin
        cls          = '0;
        cls.byte_val = byte_in;
        cls.is_bs    = (byte_in == CH_BS);
        cls.is_bel   = (byte_in == CH_BEL);
        cls.is_esc   = (byte_in == CH_ESC);
        cls.is_lbr   = (byte_in == CH_LBR);
        cls.is_rbr   = (byte_in == CH_RBR);
        cls.is_cr    = (byte_in == CH_CR);
        cls.is_lf    = (byte_in == CH_LF);
        cls.is_final = (byte_in >= FINAL_LO) && (byte_in <= FINAL_HI);
        cls.is_semi  = (byte_in == CH_SEMI);
        cls.is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
        cls.is_ws    = (byte_in == CH_SPACE) || ((byte_in >= CH_TAB) && (byte_in <= CH_CR));
        cls.is_plus  = (byte_in == CH_PLUS);
        cls.is_minus = (byte_in == CH_MINUS);
        case (byte_in)
            CH_H, CH_F: cls.fin = FIN_POS;
            CH_J:       cls.fin = FIN_CLR;
            CH_K:       cls.fin = FIN_EL;
            CH_A:       cls.fin = FIN_UP;
            CH_B:       cls.fin = FIN_DN;
            CH_C:       cls.fin = FIN_RT;
            CH_D:       cls.fin = FIN_LT;
            CH_M:       cls.fin = FIN_SGR;
            default:    cls.fin = FIN_NONE;
        endcase
    end

endmodule

>>> hdl/ater_cmdq.sv
module ater_cmdq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ater_pkg::cls_t push_word,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output ater_pkg::cls_t pop_word
);
    import ater_pkg::*;

    cls_t       mem [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign pop_word = mem[rp_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    // Pointers and fill level
    always_comb
    begin
        wp_next    = do_push ? ~wp_reg : wp_reg;
        rp_next    = do_pop ? ~rp_reg : rp_reg;
        count_next = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wp_reg] <= push_word;
        end
    end

endmodule

>>> hdl/ater_exec.sv
module ater_exec #(
    parameter int GLYPH_WIDTH  = 12,
    parameter int GLYPH_HEIGHT = 16,
    parameter int LINE_PITCH   = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  ater_pkg::cls_t q_word,
    output logic           q_pop,
    input  logic           room,
    input  logic [10:0]    screen_width,
    input  logic [10:0]    screen_height,
    output logic [1:0]     res_count,
    output ater_pkg::res_t res_a,
    output ater_pkg::res_t res_b
);
    import ater_pkg::*;

    localparam logic signed [19:0] GW_S = 20'(GLYPH_WIDTH);
    localparam logic signed [19:0] GH_S = 20'(GLYPH_HEIGHT);
    localparam logic signed [19:0] LP_S = 20'(LINE_PITCH);
    localparam logic [10:0] GW_11 = 11'(GLYPH_WIDTH);
    localparam logic [11:0] GW_12 = 12'(GLYPH_WIDTH);
    localparam logic [11:0] LP_12 = 12'(LINE_PITCH);
    localparam logic signed [13:0] LP_14 = 14'(LINE_PITCH);

    // Parser and cursor state
    logic               esc_reg, esc_next;
    logic               csi_reg, csi_next;
    logic               osc_reg, osc_next;
    logic [10:0]        cx_reg, cx_next;
    logic [10:0]        cy_reg, cy_next;
    logic [2:0]         fore_reg, fore_next;
    logic [2:0]         back_reg, back_next;
    logic [2:0]         pf_reg, pf_next;
    logic [2:0]         pb_reg, pb_next;
    logic signed [12:0] first_reg, first_next;
    logic signed [12:0] second_reg, second_next;
    logic [11:0]        field_reg, field_next;
    logic [1:0]         idx_reg, idx_next;
    logic [1:0]         ph_reg, ph_next;
    logic               neg_reg, neg_next;
    logic               jok_reg, jok_next;

    // Field close: value and its side effects
    logic signed [12:0] ef_v, ef_first, ef_second, ef_off;
    logic [2:0]         ef_pf, ef_pb;
    logic [1:0]         ef_idx;

    assign q_pop = q_valid && room;

    always_comb
    begin
        ef_v      = neg_reg ? -$signed({1'b0, field_reg}) : $signed({1'b0, field_reg});
        ef_first  = (idx_reg == 2'd0) ? ef_v : first_reg;
        ef_second = (idx_reg == 2'd1) ? ef_v : second_reg;
        ef_pf     = pf_reg;
        ef_pb     = pb_reg;
        ef_off    = 13'sd0;
        if (ef_v == 13'sd0)
        begin
            ef_pf = FORE_RESET;
            ef_pb = BACK_RESET;
        end
        else if (ef_v >= 13'sd30 && ef_v <= 13'sd37)
        begin
            ef_off = ef_v - 13'sd30;
            ef_pf  = ef_off[2:0];
        end
        else if (ef_v >= 13'sd40 && ef_v <= 13'sd47)
        begin
            ef_off = ef_v - 13'sd40;
            ef_pb  = ef_off[2:0];
        end
        ef_idx = (idx_reg < 2'd2) ? idx_reg + 2'd1 : idx_reg;
    end

    // Execute one word
    always_comb
    begin
        logic        wrap;
        logic        scroll;
        logic [11:0] y12;
        logic [10:0] ny;
        logic [10:0] nx;
        logic        jok;
        logic [15:0] acc;
        logic signed [19:0] w20, h20, cx20, cy20, cnt, row, col, tx, ty, lim;
        res_t        gword;
        res_t        fword;
        logic        fhit;

        esc_next    = esc_reg;
        csi_next    = csi_reg;
        osc_next    = osc_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        fore_next   = fore_reg;
        back_next   = back_reg;
        pf_next     = pf_reg;
        pb_next     = pb_reg;
        first_next  = first_reg;
        second_next = second_reg;
        field_next  = field_reg;
        idx_next    = idx_reg;
        ph_next     = ph_reg;
        neg_next    = neg_reg;
        jok_next    = jok_reg;
        res_count   = 2'd0;
        res_a       = '0;
        res_b       = '0;
        wrap        = 1'b0;
        scroll      = 1'b0;
        y12         = {1'b0, cy_reg} + LP_12;
        ny          = cy_reg;
        nx          = cx_reg;
        jok         = 1'b0;
        acc         = {4'd0, field_reg} * 16'd10 + {12'd0, q_word.byte_val[3:0]};
        w20         = {9'd0, screen_width};
        h20         = {9'd0, screen_height};
        cx20        = {9'd0, cx_reg};
        cy20        = {9'd0, cy_reg};
        cnt         = (ef_first <= 13'sd0) ? 20'sd1 : 20'(ef_first);
        row         = (ef_first < 13'sd1) ? 20'sd1 : 20'(ef_first);
        col         = (ef_second < 13'sd1) ? 20'sd1 : 20'(ef_second);
        tx          = cx20;
        ty          = cy20;
        lim         = 20'sd0;
        gword       = '0;
        fword       = '0;
        fhit        = 1'b0;

        if (!q_pop)
        begin
            res_count = 2'd0;
        end
        else if (q_word.is_bs)
        begin
            // Backspace works in every parse state
            if (cx_reg >= GW_11)
            begin
                cx_next = cx_reg - GW_11;
            end
        end
        else if (osc_reg)
        begin
            if (q_word.is_bel)
            begin
                osc_next = 1'b0;
            end
        end
        else if (!esc_reg)
        begin
            if (q_word.is_esc)
            begin
                esc_next = 1'b1;
                csi_next = 1'b0;
            end
            else if (q_word.is_cr)
            begin
                cx_next = 11'd0;
            end
            else
            begin
                // Line feed, or glyph with wrap at the right edge
                wrap   = q_word.is_lf || (({1'b0, cx_reg} + GW_12) > {1'b0, screen_width});
                scroll = wrap && ($signed({2'b0, y12}) > ($signed({3'b0, screen_height}) - LP_14));
                ny     = wrap ? (scroll ? cy_reg : y12[10:0]) : cy_reg;
                nx     = wrap ? 11'd0 : cx_reg;
                gword.command    = CMD_GLYPH;
                gword.pos_x      = nx;
                gword.pos_y      = ny;
                gword.glyph      = q_word.byte_val;
                gword.fore_index = fore_reg;
                gword.back_index = back_reg;
                if (scroll)
                begin
                    res_a.command = CMD_SCROLL;
                    if (q_word.is_lf)
                    begin
                        res_a.last = 1'b1;
                        res_count  = 2'd1;
                    end
                    else
                    begin
                        res_b      = gword;
                        res_b.last = 1'b1;
                        res_count  = 2'd2;
                    end
                end
                else if (!q_word.is_lf)
                begin
                    res_a      = gword;
                    res_a.last = 1'b1;
                    res_count  = 2'd1;
                end
                cx_next = q_word.is_lf ? 11'd0 : nx + GW_11;
                cy_next = ny;
            end
        end
        else if (!csi_reg)
        begin
            if (q_word.is_lbr)
            begin
                csi_next    = 1'b1;
                first_next  = 13'sd0;
                second_next = 13'sd0;
                field_next  = 12'd0;
                idx_next    = 2'd0;
                ph_next     = PH_LEAD;
                neg_next    = 1'b0;
                jok_next    = 1'b1;
                pf_next     = fore_reg;
                pb_next     = back_reg;
            end
            else if (q_word.is_rbr)
            begin
                osc_next = 1'b1;
                esc_next = 1'b0;
            end
            else
            begin
                esc_next = 1'b0;
            end
        end
        else if (!q_word.is_final)
        begin
            // Parameter text
            jok = jok_reg && (ph_reg == PH_LEAD) && (idx_reg == 2'd0)
                  && (q_word.byte_val == CH_TWO);
            if (q_word.is_semi)
            begin
                first_next  = ef_first;
                second_next = ef_second;
                pf_next     = ef_pf;
                pb_next     = ef_pb;
                idx_next    = ef_idx;
                ph_next     = PH_LEAD;
                neg_next    = 1'b0;
                field_next  = 12'd0;
            end
            else
            begin
                case (ph_reg)
                    PH_LEAD:
                    begin
                        if (q_word.is_ws)
                        begin
                            ph_next = PH_LEAD;
                        end
                        else if (q_word.is_plus)
                        begin
                            ph_next = PH_SIGN;
                        end
                        else if (q_word.is_minus)
                        begin
                            neg_next = 1'b1;
                            ph_next  = PH_SIGN;
                        end
                        else if (q_word.is_digit)
                        begin
                            field_next = {8'd0, q_word.byte_val[3:0]};
                            ph_next    = PH_DIGIT;
                        end
                        else
                        begin
                            ph_next = PH_STOP;
                        end
                    end
                    PH_SIGN:
                    begin
                        if (q_word.is_digit)
                        begin
                            field_next = {8'd0, q_word.byte_val[3:0]};
                            ph_next    = PH_DIGIT;
                        end
                        else
                        begin
                            ph_next = PH_STOP;
                        end
                    end
                    PH_DIGIT:
                    begin
                        if (q_word.is_digit)
                        begin
                            field_next = (acc > {4'd0, FIELD_MAX}) ? FIELD_MAX : acc[11:0];
                        end
                        else
                        begin
                            ph_next = PH_STOP;
                        end
                    end
                    default:
                    begin
                        ph_next = PH_STOP;
                    end
                endcase
            end
            jok_next = jok;
        end
        else
        begin
            // Final byte: close the field, then act on it
            first_next  = ef_first;
            second_next = ef_second;
            pf_next     = ef_pf;
            pb_next     = ef_pb;
            idx_next    = ef_idx;
            ph_next     = PH_LEAD;
            neg_next    = 1'b0;
            field_next  = 12'd0;
            esc_next    = 1'b0;
            csi_next    = 1'b0;
            fword.command     = CMD_FILL;
            fword.rect_height = 11'(LINE_PITCH);
            fword.back_index  = back_reg;
            fword.last        = 1'b1;
            case (q_word.fin)
                FIN_POS:
                begin
                    lim = w20 - GW_S;
                    lim = (lim < 20'sd0) ? 20'sd0 : lim;
                    tx  = (col - 20'sd1) * GW_S;
                    tx  = (tx > lim) ? lim : tx;
                    lim = h20 - LP_S;
                    lim = (lim < 20'sd0) ? 20'sd0 : lim;
                    ty  = (row - 20'sd1) * GH_S;
                    ty  = (ty > lim) ? lim : ty;
                end
                FIN_CLR:
                begin
                    if (jok_reg)
                    begin
                        fword.rect_width  = screen_width;
                        fword.rect_height = screen_height;
                        fword.back_index  = 3'd0;
                        fhit = 1'b1;
                        tx   = 20'sd0;
                        ty   = 20'sd0;
                    end
                end
                FIN_EL:
                begin
                    fword.pos_y = cy_reg;
                    if (ef_first == 13'sd0)
                    begin
                        lim = w20 - cx20;
                        fword.pos_x      = cx_reg;
                        fword.rect_width = (lim < 20'sd0) ? 11'd0 : lim[10:0];
                        fhit = 1'b1;
                    end
                    else if (ef_first == 13'sd1)
                    begin
                        fword.rect_width = cx_reg;
                        fhit = 1'b1;
                    end
                    else if (ef_first == 13'sd2)
                    begin
                        fword.rect_width = screen_width;
                        fhit = 1'b1;
                    end
                end
                FIN_UP:
                begin
                    ty = cy20 - cnt * LP_S;
                    ty = (ty < 20'sd0) ? 20'sd0 : ty;
                end
                FIN_DN:
                begin
                    ty  = cy20 + cnt * LP_S;
                    lim = h20 - LP_S;
                    ty  = (ty > lim) ? lim : ty;
                    ty  = (ty < 20'sd0) ? 20'sd0 : ty;
                end
                FIN_RT:
                begin
                    tx  = cx20 + cnt * GW_S;
                    lim = w20 - GW_S;
                    tx  = (tx > lim) ? lim : tx;
                    tx  = (tx < 20'sd0) ? 20'sd0 : tx;
                end
                FIN_LT:
                begin
                    tx = cx20 - cnt * GW_S;
                    tx = (tx < 20'sd0) ? 20'sd0 : tx;
                end
                FIN_SGR:
                begin
                    fore_next = ef_pf;
                    back_next = ef_pb;
                end
                default:
                begin
                    fhit = 1'b0;
                end
            endcase
            cx_next = tx[10:0];
            cy_next = ty[10:0];
            if (fhit)
            begin
                res_a     = fword;
                res_count = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg    <= 1'b0;
            csi_reg    <= 1'b0;
            osc_reg    <= 1'b0;
            cx_reg     <= 11'd0;
            cy_reg     <= 11'd0;
            fore_reg   <= FORE_RESET;
            back_reg   <= BACK_RESET;
            pf_reg     <= FORE_RESET;
            pb_reg     <= BACK_RESET;
            first_reg  <= 13'sd0;
            second_reg <= 13'sd0;
            field_reg  <= 12'd0;
            idx_reg    <= 2'd0;
            ph_reg     <= PH_LEAD;
            neg_reg    <= 1'b0;
            jok_reg    <= 1'b0;
        end
        else
        begin
            esc_reg    <= esc_next;
            csi_reg    <= csi_next;
            osc_reg    <= osc_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            fore_reg   <= fore_next;
            back_reg   <= back_next;
            pf_reg     <= pf_next;
            pb_reg     <= pb_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            field_reg  <= field_next;
            idx_reg    <= idx_next;
            ph_reg     <= ph_next;
            neg_reg    <= neg_next;
            jok_reg    <= jok_next;
        end
    end

endmodule

>>> hdl/ater_resq.sv
module ater_resq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [1:0]     push_count,
    input  ater_pkg::res_t push_a,
    input  ater_pkg::res_t push_b,
    output logic           room,
    input  logic           pop,
    output logic           empty,
    output ater_pkg::res_t head
);
    import ater_pkg::*;

    res_t       mem [4];
    logic [1:0] wp_reg, wp_next;
    logic [1:0] rp_reg, rp_next;
    logic [2:0] count_reg, count_next;
    logic       do_pop;

    // Room for two words, so a byte never has to split its results
    assign room   = (count_reg <= 3'd2);
    assign empty  = (count_reg == 3'd0);
    assign head   = mem[rp_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        wp_next    = wp_reg + push_count;
        rp_next    = do_pop ? rp_reg + 2'd1 : rp_reg;
        count_next = count_reg + {1'b0, push_count} - {2'd0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= 2'd0;
            rp_reg    <= 2'd0;
            count_reg <= 3'd0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem[wp_reg] <= push_a;
        end
        if (push_count == 2'd2)
        begin
            mem[wp_reg + 2'd1] <= push_b;
        end
    end

endmodule

>>> dv/ansi_terminal_escape_renderer_tb.sv
module ansi_terminal_escape_renderer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ater_pkg::*;

    localparam int GW = 12;
    localparam int GH = 16;
    localparam int LP = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 550;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  byte_in = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  command;
    logic [10:0] pos_x, pos_y, rect_width, rect_height;
    logic [7:0]  glyph;
    logic [2:0]  fore_index, back_index;
    logic        last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    ansi_terminal_escape_renderer dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .byte_in(byte_in),
        .empty(empty), .pop(pop), .command(command), .pos_x(pos_x), .pos_y(pos_y),
        .rect_width(rect_width), .rect_height(rect_height), .glyph(glyph),
        .fore_index(fore_index), .back_index(back_index), .last(last),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // Pending bytes and expected draw commands
    logic [7:0] byte_backlog[$];
    res_t       draw_cmds_due[$];
    int         errors = 0;
    int         bytes_queued = 0;
    int         bytes_taken = 0;
    int         cmds_seen = 0;
    int         cycles = 0;
    bit         calm = 0;

    // Renderer state mirror
    int       scr_w = WIDTH_RESET, scr_h = HEIGHT_RESET;
    bit       esc_on, csi_on, osc_on;
    int       cur_x, cur_y;
    bit [2:0] fg = FORE_RESET, bg = BACK_RESET, pend_fg = FORE_RESET, pend_bg = BACK_RESET;
    int       num0, num1, field_val;
    int       field_idx;
    bit [1:0] phase;
    bit       neg, j_ok;

    function automatic int lo(input int v, input int m);
        return v < m ? m : v;
    endfunction

    function automatic int hi(input int v, input int m);
        return v > m ? m : v;
    endfunction

    task automatic add_cmd(input logic [1:0] c, input int x, input int y, input int w,
                           input int h, input int g, input bit [2:0] f, input bit [2:0] b);
        res_t r;
        r.command = c;
        r.pos_x = 11'(lo(x, 0));
        r.pos_y = 11'(lo(y, 0));
        r.rect_width = 11'(lo(w, 0));
        r.rect_height = 11'(lo(h, 0));
        r.glyph = 8'(g);
        r.fore_index = f;
        r.back_index = b;
        r.last = 1'b0;
        draw_cmds_due.insert(draw_cmds_due.size(), r);
    endtask

    task automatic scroll_if_low();
        if (cur_y > scr_h - LP) begin
            add_cmd(CMD_SCROLL, 0, 0, 0, 0, 0, 3'd0, 3'd0);
            cur_y = lo(cur_y - LP, 0) & 'h7FF;
        end
    endtask

    task automatic close_field();
        int v;
        v = neg ? -field_val : field_val;
        if (field_idx == 0) num0 = v;
        else if (field_idx == 1) num1 = v;
        if (v == 0) begin
            pend_fg = FORE_RESET;
            pend_bg = BACK_RESET;
        end else if (v >= 30 && v <= 37) pend_fg = 3'(v - 30);
        else if (v >= 40 && v <= 47) pend_bg = 3'(v - 40);
        if (field_idx < 2) field_idx++;
        phase = PH_LEAD;
        neg = 0;
        field_val = 0;
    endtask

    task automatic param_char(input logic [7:0] b);
        bit dig, jk;
        dig = b >= CH_ZERO && b <= CH_NINE;
        jk = j_ok && phase == PH_LEAD && field_idx == 0 && b == CH_TWO;
        if (b == CH_SEMI) close_field();
        else if (phase == PH_LEAD) begin
            if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) ;
            else if (b == CH_PLUS) phase = PH_SIGN;
            else if (b == CH_MINUS) begin
                neg = 1;
                phase = PH_SIGN;
            end else if (dig) begin
                field_val = b - CH_ZERO;
                phase = PH_DIGIT;
            end else phase = PH_STOP;
        end else if (phase == PH_SIGN) begin
            if (dig) begin
                field_val = b - CH_ZERO;
                phase = PH_DIGIT;
            end else phase = PH_STOP;
        end else if (phase == PH_DIGIT) begin
            if (dig) field_val = hi(field_val * 10 + (b - CH_ZERO), FIELD_MAX);
            else phase = PH_STOP;
        end
        j_ok = jk;
    endtask

    task automatic do_final(input logic [7:0] b);
        int cx, cy, cnt;
        cx = cur_x;
        cy = cur_y;
        cnt = num0 <= 0 ? 1 : num0;
        if (b == CH_H || b == CH_F) begin
            cx = hi((lo(num1, 1) - 1) * GW, lo(scr_w - GW, 0));
            cy = hi((lo(num0, 1) - 1) * GH, lo(scr_h - LP, 0));
        end else if (b == CH_J) begin
            if (j_ok) begin
                add_cmd(CMD_FILL, 0, 0, scr_w, scr_h, 0, 3'd0, 3'd0);
                cx = 0;
                cy = 0;
            end
        end else if (b == CH_K) begin
            if (num0 == 0) add_cmd(CMD_FILL, cx, cy, scr_w - cx, LP, 0, 3'd0, bg);
            else if (num0 == 1) add_cmd(CMD_FILL, 0, cy, cx, LP, 0, 3'd0, bg);
            else if (num0 == 2) add_cmd(CMD_FILL, 0, cy, scr_w, LP, 0, 3'd0, bg);
        end else if (b == CH_A) cy = lo(cy - cnt * LP, 0);
        else if (b == CH_B) cy = lo(hi(cy + cnt * LP, scr_h - LP), 0);
        else if (b == CH_C) cx = lo(hi(cx + cnt * GW, scr_w - GW), 0);
        else if (b == CH_D) cx = lo(cx - cnt * GW, 0);
        else if (b == CH_M) begin
            fg = pend_fg;
            bg = pend_bg;
        end
        cur_x = cx & 'h7FF;
        cur_y = cy & 'h7FF;
    endtask

    // Expected commands for one accepted byte
    task automatic render_byte(input logic [7:0] b);
        int count_prior;
        count_prior = draw_cmds_due.size();
        if (b == CH_BS) begin
            if (cur_x >= GW) cur_x -= GW;
        end else if (osc_on) begin
            if (b == CH_BEL) osc_on = 0;
        end else if (!esc_on) begin
            if (b == CH_ESC) begin
                esc_on = 1;
                csi_on = 0;
            end else if (b == CH_CR) cur_x = 0;
            else if (b == CH_LF) begin
                cur_x = 0;
                cur_y = (cur_y + LP) & 'hFFF;
                scroll_if_low();
            end else begin
                if (cur_x + GW > scr_w) begin
                    cur_x = 0;
                    cur_y = (cur_y + LP) & 'hFFF;
                    scroll_if_low();
                end
                add_cmd(CMD_GLYPH, cur_x, cur_y, 0, 0, b, fg, bg);
                cur_x = (cur_x + GW) & 'h7FF;
            end
        end else if (!csi_on) begin
            if (b == CH_LBR) begin
                csi_on = 1;
                num0 = 0;
                num1 = 0;
                field_val = 0;
                field_idx = 0;
                phase = PH_LEAD;
                neg = 0;
                j_ok = 1;
                pend_fg = fg;
                pend_bg = bg;
            end else if (b == CH_RBR) begin
                osc_on = 1;
                esc_on = 0;
            end else esc_on = 0;
        end else if (b < FINAL_LO || b > FINAL_HI) param_char(b);
        else begin
            close_field();
            do_final(b);
            esc_on = 0;
            csi_on = 0;
        end
        if (draw_cmds_due.size() > count_prior)
            draw_cmds_due[draw_cmds_due.size() - 1].last = 1'b1;
    endtask

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Driver: push bytes from the backlog
    int push_gap = 0;
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) push <= 1'b0;
        else begin
            if (push && !full) begin
                render_byte(byte_in);
                bytes_taken++;
            end
            if (!push || !full) begin
                if (push_gap > 0) begin
                    push_gap--;
                    push <= 1'b0;
                end else if (byte_backlog.size() > 0) begin
                    byte_in <= byte_backlog.pop_front();
                    push <= 1'b1;
                    push_gap = pick_gap();
                end else push <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Monitor: pop words and compare
    int pop_gap = 0;
    always @(posedge clk or negedge rst_n) begin
        res_t e;
        if (!rst_n) pop <= 1'b0;
        else begin
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("%0t: timeout", $realtime);
                $display("ansi_terminal_escape_renderer regression: fail");
                $finish;
            end
            if (pop && !empty) begin
                cmds_seen++;
                if (draw_cmds_due.size() == 0) begin
                    $display("%0t: unexpected word, command %0d", $realtime, command);
                    errors++;
                end else begin
                    e = draw_cmds_due.pop_front();
                    check_field("command", e.command, command);
                    check_field("pos_x", e.pos_x, pos_x);
                    check_field("pos_y", e.pos_y, pos_y);
                    check_field("rect_width", e.rect_width, rect_width);
                    check_field("rect_height", e.rect_height, rect_height);
                    check_field("glyph", e.glyph, glyph);
                    check_field("fore_index", e.fore_index, fore_index);
                    check_field("back_index", e.back_index, back_index);
                    check_field("last", e.last, last);
                end
            end
            if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                pop_gap = pick_gap();
            end
        end
    end

    task automatic add_byte(input logic [7:0] b);
        byte_backlog.insert(byte_backlog.size(), b);
        bytes_queued++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    // One CSI sequence with random parameters
    task automatic add_csi();
        int nf, r;
        logic [7:0] fins[10];
        fins = '{CH_H, CH_F, CH_J, CH_K, CH_A, CH_B, CH_C, CH_D, CH_M, CH_M};
        add_byte(CH_ESC);
        add_byte(CH_LBR);
        nf = $urandom_range(0, 3);
        for (int i = 0; i < nf; i++) begin
            if (i > 0) add_byte(CH_SEMI);
            r = $urandom_range(99);
            if (r < 8) add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            if (r >= 8 && r < 14) add_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            r = $urandom_range(99);
            if (r < 45) add_text($sformatf("%0d", $urandom_range(0, 9)));
            else if (r < 75) add_text($sformatf("%0d", $urandom_range(0, 1) ?
                                                 $urandom_range(30, 37) :
                                                 $urandom_range(40, 47)));
            else if (r < 88) add_text($sformatf("%0d", $urandom_range(10, 99)));
            else if (r < 94) add_text($sformatf("%0d", $urandom_range(100, 99999)));
            else add_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h21, 8'h3F)) : CH_BS);
        end
        if ($urandom_range(9) == 0) add_byte(8'($urandom_range(FINAL_LO, FINAL_HI)));
        else add_byte(fins[$urandom_range(0, 9)]);
    endtask

    task automatic add_random_burst();
        int r;
        r = $urandom_range(99);
        if (r < 35) begin
            repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(8'h20, 8'h7E)));
        end else if (r < 50) add_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
        else if (r < 75) add_csi();
        else if (r < 80) begin
            add_byte(CH_ESC);
            add_byte(CH_RBR);
            repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(8'h08, 8'hFF)));
            add_byte(CH_BEL);
        end else if (r < 84) begin
            add_byte(CH_ESC);
            add_byte(8'($urandom_range(0, 255)));
        end else if (r < 88) add_byte(CH_BS);
        else add_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_idle();
        while (byte_backlog.size() > 0 || push || draw_cmds_due.size() > 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input int val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == ADDR_WIDTH_REG) scr_w = val & 'h7FF;
        else scr_h = val & 'h7FF;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Stimulus: directed bytes, then random phases over several screen sizes
    initial begin
        int sizes_w[5], sizes_h[5];
        int per_phase;
        sizes_w = '{1280, 12, 2047, 0, 40};
        sizes_h = '{720, 16, 2047, 0, 48};
        sizes_w[3] = $urandom_range(12, 300);
        sizes_h[3] = $urandom_range(16, 200);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        per_phase = ITEM_TARGET / 5;

        for (int ph = 0; ph < 5; ph++) begin
            reg_write(ADDR_WIDTH_REG, sizes_w[ph]);
            reg_write(ADDR_HEIGHT_REG, sizes_h[ph]);
            calm = (ph == 2);
            if (ph == 0) begin
                add_byte(8'h00);
                add_byte(8'hFF);
                add_byte(CH_BS);
                add_byte(CH_CR);
                add_byte(CH_LF);
                add_text("\033[2J");
                add_text("\033[5;10H");
                add_text("\033[K\033[1K\033[2K\033[7K");
                add_text("\033[31;44mZ\033[-0m");
                add_text("\033]title\007\033x");
                add_text("\033[9999;9999f\033[3C\033[2B\033[A\033[D\033[~");
            end
            while (bytes_queued < per_phase * (ph + 1)) add_random_burst();
            wait_idle();
        end

        $display("Covered %0d bytes and %0d commands over five screen sizes,",
                 bytes_taken, cmds_seen);
        $display("including minimum and maximum width and height.");
        if (errors == 0)
            $display("ansi_terminal_escape_renderer regression: pass");
        else
            $display("ansi_terminal_escape_renderer regression: fail");
        $finish;
    end
endmodule

>>> files.f
hdl/ater_pkg.sv
hdl/ater_front.sv
hdl/ater_cmdq.sv
hdl/ater_exec.sv
hdl/ater_resq.sv
hdl/ansi_terminal_escape_renderer.sv
dv/ansi_terminal_escape_renderer_tb.sv
